@@ rtl/jsu_pkg.sv @@
// jsu_pkg: shared types, command codes and helpers for the json string unescaper
// depends on nothing; imported by every rtl module of the block
`timescale 1ns / 1ps

package jsu_pkg;

  // default depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // width of a unicode scalar value
  localparam int CP_W = 21;

  // command operations
  localparam logic [1:0] OP_RAW  = 2'd0;  // pass byte through unchanged
  localparam logic [1:0] OP_UTF8 = 2'd1;  // encode code point as utf-8
  localparam logic [1:0] OP_END  = 2'd2;  // string ended correctly
  localparam logic [1:0] OP_ERR  = 2'd3;  // error

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef struct packed {
    logic [1:0]      op;
    logic [CP_W-1:0] cp;
  } cmd_t;

  // bit 4 set when the byte is a hex digit, low nibble is its value
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ rtl/jsu_front.sv @@
// jsu_front: accepts string body bytes, tracks escape state, issues commands
// depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       input_end,
  output logic       push,
  output cmd_t       cmd
);

  localparam logic [2:0] M_PLAIN = 3'd0;
  localparam logic [2:0] M_ESC   = 3'd1;
  localparam logic [2:0] M_HEX1  = 3'd2;
  localparam logic [2:0] M_LOWBS = 3'd3;
  localparam logic [2:0] M_LOWU  = 3'd4;
  localparam logic [2:0] M_HEX2  = 3'd5;

  logic [2:0]  mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_acc, code_acc_next;
  logic [9:0]  high_part, high_part_next;
  logic [4:0]  hex;
  logic [15:0] acc_new;
  logic [10:0] plane;

  assign hex     = hex_decode(in_byte);
  assign acc_new = {code_acc[11:0], hex[3:0]};
  // high surrogate plus 0x40 gives bits 20..10 of the combined code point
  assign plane   = {1'b0, high_part} + 11'h040;

  always_comb begin
    mode_next      = mode;
    hex_count_next = hex_count;
    code_acc_next  = code_acc;
    high_part_next = high_part;
    push           = 1'b0;
    cmd.op         = OP_ERR;
    cmd.cp         = '0;
    if (accept) begin
      if (input_end) begin
        push           = 1'b1;
        cmd.op         = OP_ERR;
        mode_next      = M_PLAIN;
        hex_count_next = 2'd0;
        code_acc_next  = 16'd0;
        high_part_next = 10'd0;
      end else begin
        unique case (mode) inside
          M_PLAIN: begin
            if (in_byte == 8'h22) begin
              push   = 1'b1;
              cmd.op = OP_END;
            end else if (in_byte < 8'h20) begin
              push   = 1'b1;
              cmd.op = OP_ERR;
            end else if (in_byte == 8'h5C) begin
              mode_next = M_ESC;
            end else begin
              push   = 1'b1;
              cmd.op = OP_RAW;
              cmd.cp = CP_W'(in_byte);
            end
          end
          M_ESC: begin
            push      = 1'b1;
            cmd.op    = OP_RAW;
            mode_next = M_PLAIN;
            case (in_byte) inside
              8'h22, 8'h5C, 8'h2F: cmd.cp = CP_W'(in_byte);
              8'h62: cmd.cp = CP_W'(8'h08);
              8'h66: cmd.cp = CP_W'(8'h0C);
              8'h6E: cmd.cp = CP_W'(8'h0A);
              8'h72: cmd.cp = CP_W'(8'h0D);
              8'h74: cmd.cp = CP_W'(8'h09);
              8'h75: begin
                push           = 1'b0;
                mode_next      = M_HEX1;
                hex_count_next = 2'd0;
                code_acc_next  = 16'd0;
              end
              default: cmd.op = OP_ERR;
            endcase
          end
          M_HEX1, M_HEX2: begin
            if (!hex[4]) begin
              push   = 1'b1;
              cmd.op = OP_ERR;
            end else if (hex_count != 2'd3) begin
              hex_count_next = hex_count + 2'd1;
              code_acc_next  = acc_new;
            end else begin
              hex_count_next = 2'd0;
              code_acc_next  = 16'd0;
              if (mode == M_HEX1) begin
                if (acc_new[15:10] == 6'b110110) begin
                  // high surrogate, low half must follow
                  high_part_next = acc_new[9:0];
                  mode_next      = M_LOWBS;
                end else begin
                  push      = 1'b1;
                  cmd.op    = OP_UTF8;
                  cmd.cp    = CP_W'(acc_new);
                  mode_next = M_PLAIN;
                end
              end else if (acc_new[15:10] != 6'b110111) begin
                push   = 1'b1;
                cmd.op = OP_ERR;
              end else begin
                push           = 1'b1;
                cmd.op         = OP_UTF8;
                cmd.cp         = {plane[CP_W-11:0], acc_new[9:0]};
                mode_next      = M_PLAIN;
                high_part_next = 10'd0;
              end
            end
          end
          M_LOWBS: begin
            if (in_byte != 8'h5C) begin
              push   = 1'b1;
              cmd.op = OP_ERR;
            end else begin
              mode_next = M_LOWU;
            end
          end
          M_LOWU: begin
            if (in_byte != 8'h75) begin
              push   = 1'b1;
              cmd.op = OP_ERR;
            end else begin
              mode_next      = M_HEX2;
              hex_count_next = 2'd0;
              code_acc_next  = 16'd0;
            end
          end
          default: begin
            push   = 1'b1;
            cmd.op = OP_ERR;
          end
        endcase
        // end of string and every error send the state back to plain content
        if (push && (cmd.op == OP_END || cmd.op == OP_ERR)) begin
          mode_next      = M_PLAIN;
          hex_count_next = 2'd0;
          code_acc_next  = 16'd0;
          high_part_next = 10'd0;
          cmd.cp         = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_PLAIN;
      hex_count <= 2'd0;
      code_acc  <= 16'd0;
      high_part <= 10'd0;
    end else begin
      mode      <= mode_next;
      hex_count <= hex_count_next;
      code_acc  <= code_acc_next;
      high_part <= high_part_next;
    end
  end

endmodule

@@ rtl/jsu_queue.sv @@
// jsu_queue: small command queue between the front and the back
// depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rd_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/jsu_back.sv @@
// jsu_back: expands queued commands into result transactions, utf-8 encoding
// depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last
);

  logic [1:0] idx;
  logic [1:0] final_idx;
  logic [7:0] sel_byte;
  logic [1:0] sel_kind;
  logic       load;

  // number of result bytes minus one
  always_comb begin
    final_idx = 2'd0;
    if (cmd.op == OP_UTF8) begin
      if (cmd.cp < CP_W'(21'h80)) begin
        final_idx = 2'd0;
      end else if (cmd.cp < CP_W'(21'h800)) begin
        final_idx = 2'd1;
      end else if (cmd.cp < CP_W'(21'h10000)) begin
        final_idx = 2'd2;
      end else begin
        final_idx = 2'd3;
      end
    end
  end

  always_comb begin
    sel_byte = 8'h00;
    sel_kind = KIND_DATA;
    unique case (cmd.op)
      OP_RAW: sel_byte = cmd.cp[7:0];
      OP_END: sel_kind = KIND_END;
      OP_ERR: sel_kind = KIND_ERR;
      OP_UTF8: begin
        // continuation byte of the slot, overridden for the lead byte
        case (final_idx - idx)
          2'd0: sel_byte = {2'b10, cmd.cp[5:0]};
          2'd1: sel_byte = {2'b10, cmd.cp[11:6]};
          2'd2: sel_byte = {2'b10, cmd.cp[17:12]};
          default: sel_byte = {2'b10, 3'b000, cmd.cp[20:18]};
        endcase
        if (idx == 2'd0) begin
          case (final_idx)
            2'd0: sel_byte = {1'b0, cmd.cp[6:0]};
            2'd1: sel_byte = {3'b110, cmd.cp[10:6]};
            2'd2: sel_byte = {4'b1110, cmd.cp[15:12]};
            default: sel_byte = {5'b11110, cmd.cp[20:18]};
          endcase
        end
      end
      default: sel_kind = KIND_ERR;
    endcase
  end

  assign load = cmd_valid && (!out_valid || out_ready);
  assign pop  = load && (idx == final_idx);

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      kind     <= sel_kind;
      last     <= (idx == final_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= (idx == final_idx) ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/json_string_unescape_unit.sv @@
// json_string_unescape_unit: top level of the json string body unescaper
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back
`timescale 1ns / 1ps

// usage
//   input channel (in_valid/in_ready, in_byte, input_end) takes one byte of a
//   json string body per transaction, starting right after the opening quote;
//   input_end marks end of text and always yields an error result
//   output channel (out_valid/out_ready, out_byte, kind, last) returns one
//   result per transaction: kind 0 data byte, 1 string closed, 2 error;
//   last flags the final result caused by one input transaction
//   bytes that only advance escape parsing produce no result at all
// throughput: one input transaction per cycle while in_ready is high; the
//   back emits one result per cycle while out_ready is high, so a \u escape
//   that expands to up to four utf-8 bytes is absorbed by the six or more
//   input bytes it takes plus the command queue
// order: on acceptance an input's command is written to the queue, and its
//   first result is loaded into the output register once it heads the queue
// stall: when out_ready stays low the output register holds, the queue fills,
//   and in_ready drops once the queue is full; nothing is lost or repeated
// reset: rst is synchronous; escape state returns to plain content, the queue
//   empties and out_valid clears
module json_string_unescape_unit
  import jsu_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       input_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t head_cmd;

  // front never pushes more than one command per transaction, so a free slot
  // is all that is needed to take the next byte
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .input_end (input_end),
    .push      (push),
    .cmd       (push_cmd)
  );

  jsu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (push_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (head_cmd)
  );

  // back walks the head command one byte per cycle while out_ready is high
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd       (head_cmd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for json_string_unescape_unit, random and directed string bodies
// depends on jsu_pkg for the result kind codes and on the rtl of the unescaper
`timescale 1ns / 1ps

module tb;
  import jsu_pkg::*;

  // special bytes of a json string body
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int HOLD_AT        = 120;   // input transactions before the long output hold
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_AT       = 300;   // input transactions before the sender drains
  localparam int CALM_ITEMS     = 60;    // no idling once this few items remain
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side

  // escape parser state of the predictor
  typedef enum logic [2:0] {
    ST_TEXT,     // plain content
    ST_ESCAPE,   // after a backslash
    ST_HEX_HI,   // hex digits of a \u escape
    ST_WANT_BS,  // high surrogate seen, backslash of the low one expected
    ST_WANT_U,   // its u expected
    ST_HEX_LO    // hex digits of the low surrogate
  } scan_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       at_end;
  } text_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } unesc_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       input_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  // stimulus and expectations
  text_item_t    text_q[$];
  unesc_result_t expected_q[$];
  int            item_total = 0;
  int            taken_cnt = 0;
  int            fail_cnt = 0;

  // predictor state
  scan_state_e scan_st = ST_TEXT;
  logic [1:0]  digit_cnt = '0;
  logic [15:0] code_val = '0;
  logic [9:0]  hi_bits = '0;

  // pacing state shared between driver and monitor
  logic calm = 1'b0;
  int   hold_left = 0;

  json_string_unescape_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .input_end (input_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int hex_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a" + 8'd10);
    if (b >= "A" && b <= "F") return int'(b - "A" + 8'd10);
    return -1;
  endfunction

  task automatic queue_output(input logic [7:0] b, input logic [1:0] k, input logic l);
    expected_q.push_back('{b, k, l});
  endtask

  // closing quote or error: single marker result and back to plain content
  task automatic close_string(input logic [1:0] k);
    scan_st   = ST_TEXT;
    digit_cnt = '0;
    code_val  = '0;
    hi_bits   = '0;
    queue_output(8'h00, k, 1'b1);
  endtask

  task automatic queue_utf8(input logic [20:0] cp);
    logic [7:0] enc [4];
    int         n;
    if (cp < 21'h80) begin
      enc[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      enc[0] = 8'hC0 | cp[10:6];
      enc[1] = 8'h80 | cp[5:0];
      n = 2;
    end else if (cp < 21'h10000) begin
      enc[0] = 8'hE0 | cp[15:12];
      enc[1] = 8'h80 | cp[11:6];
      enc[2] = 8'h80 | cp[5:0];
      n = 3;
    end else begin
      enc[0] = 8'hF0 | cp[20:18];
      enc[1] = 8'h80 | cp[17:12];
      enc[2] = 8'h80 | cp[11:6];
      enc[3] = 8'h80 | cp[5:0];
      n = 4;
    end
    for (int i = 0; i < n; i++) queue_output(enc[i], KIND_DATA, i == n - 1);
  endtask

  // advance the escape parser by one accepted byte and queue what it yields
  task automatic predict_unescape(input logic [7:0] b, input logic at_end);
    int          d;
    logic [15:0] acc;
    if (at_end) begin
      close_string(KIND_ERR);
      return;
    end
    case (scan_st) inside
      ST_TEXT: begin
        if (b == CH_QUOTE) close_string(KIND_END);
        else if (b < 8'h20) close_string(KIND_ERR);
        else if (b == CH_BSLASH) scan_st = ST_ESCAPE;
        else queue_output(b, KIND_DATA, 1'b1);
      end
      ST_ESCAPE: begin
        scan_st = ST_TEXT;
        case (b) inside
          CH_QUOTE, CH_BSLASH, "/": queue_output(b, KIND_DATA, 1'b1);
          "b": queue_output(8'h08, KIND_DATA, 1'b1);
          "f": queue_output(8'h0C, KIND_DATA, 1'b1);
          "n": queue_output(8'h0A, KIND_DATA, 1'b1);
          "r": queue_output(8'h0D, KIND_DATA, 1'b1);
          "t": queue_output(8'h09, KIND_DATA, 1'b1);
          "u": begin
            scan_st   = ST_HEX_HI;
            digit_cnt = '0;
            code_val  = '0;
          end
          default: close_string(KIND_ERR);
        endcase
      end
      ST_HEX_HI, ST_HEX_LO: begin
        d = hex_value(b);
        if (d < 0) begin
          close_string(KIND_ERR);
        end else begin
          code_val = {code_val[11:0], d[3:0]};
          if (digit_cnt != 2'd3) begin
            digit_cnt++;
          end else begin
            digit_cnt = '0;
            acc = code_val;
            code_val = '0;
            if (scan_st == ST_HEX_HI) begin
              if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                // high surrogate, wait for the low half
                hi_bits = acc[9:0];
                scan_st = ST_WANT_BS;
              end else begin
                // lone low surrogates pass as three byte sequences
                scan_st = ST_TEXT;
                queue_utf8({5'd0, acc});
              end
            end else if (acc < 16'hDC00 || acc > 16'hDFFF) begin
              close_string(KIND_ERR);
            end else begin
              queue_utf8(21'h10000 + {1'b0, hi_bits, acc[9:0]});
              scan_st = ST_TEXT;
              hi_bits = '0;
            end
          end
        end
      end
      ST_WANT_BS: begin
        if (b != CH_BSLASH) close_string(KIND_ERR);
        else scan_st = ST_WANT_U;
      end
      ST_WANT_U: begin
        if (b != "u") begin
          close_string(KIND_ERR);
        end else begin
          scan_st   = ST_HEX_LO;
          digit_cnt = '0;
          code_val  = '0;
        end
      end
      default: close_string(KIND_ERR);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic queue_byte(input logic [7:0] b, input logic e);
    text_q.push_back('{b, e});
    item_total++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return "0" + {4'd0, n};
    return (upper ? "A" : "a") + {4'd0, n} - 8'd10;
  endfunction

  // backslash, u, then four hex digits in mixed case
  task automatic queue_u_escape(input logic [15:0] v);
    queue_byte(CH_BSLASH, 1'b0);
    queue_byte("u", 1'b0);
    for (int i = 3; i >= 0; i--)
      queue_byte(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))), 1'b0);
  endtask

  // one string body: random content, mostly closed by a quote, sometimes broken
  task automatic queue_string();
    int         segs;
    int         sel;
    int         ndig;
    logic [7:0] b;
    bit         ok;
    segs = $urandom_range(0, 8);
    repeat (segs) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
        queue_byte(b, 1'b0);
      end else if (sel < 60) begin
        queue_byte(CH_BSLASH, 1'b0);
        case ($urandom_range(0, 7))
          0: queue_byte(CH_QUOTE, 1'b0);
          1: queue_byte(CH_BSLASH, 1'b0);
          2: queue_byte("/", 1'b0);
          3: queue_byte("b", 1'b0);
          4: queue_byte("f", 1'b0);
          5: queue_byte("n", 1'b0);
          6: queue_byte("r", 1'b0);
          default: queue_byte("t", 1'b0);
        endcase
      end else if (sel < 85) begin
        case ($urandom_range(0, 3))
          0: queue_u_escape(16'($urandom_range(0, 16'h7F)));
          1: queue_u_escape(16'($urandom_range(16'h80, 16'h7FF)));
          2: queue_u_escape(16'($urandom_range(0, 1) ? $urandom_range(16'h800, 16'hD7FF)
                                                     : $urandom_range(16'hE000, 16'hFFFF)));
          default: queue_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
        endcase
      end else begin
        queue_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
        queue_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      queue_byte(CH_QUOTE, 1'b0);
    end else if (sel < 80) begin
      queue_byte(8'($urandom_range(0, 255)), 1'b1);
    end else if (sel < 84) begin
      queue_byte(8'($urandom_range(0, 8'h1F)), 1'b0);
    end else if (sel < 88) begin
      // unknown escape letter
      do begin
        b = 8'($urandom_range(0, 255));
        ok = 1'b1;
        case (b) inside
          CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", "u": ok = 1'b0;
          default: ;
        endcase
      end while (!ok);
      queue_byte(CH_BSLASH, 1'b0);
      queue_byte(b, 1'b0);
    end else if (sel < 92) begin
      // bad hex digit somewhere in a \u escape
      queue_byte(CH_BSLASH, 1'b0);
      queue_byte("u", 1'b0);
      ndig = $urandom_range(0, 3);
      repeat (ndig)
        queue_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
      do b = 8'($urandom_range(0, 255)); while (hex_value(b) >= 0);
      queue_byte(b, 1'b0);
    end else if (sel < 96) begin
      // high surrogate without a following \u
      queue_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
      if ($urandom_range(0, 1)) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
      end else begin
        queue_byte(CH_BSLASH, 1'b0);
        do b = 8'($urandom_range(0, 255)); while (b == "u");
      end
      queue_byte(b, 1'b0);
    end else begin
      // low half outside the low surrogate range
      queue_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
      queue_u_escape(16'($urandom_range(0, 1) ? $urandom_range(0, 16'hDBFF)
                                              : $urandom_range(16'hE000, 16'hFFFF)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers pending bytes, random gaps, one drain pause
  // ---------------------------------------------------------------------------

  text_item_t nxt;
  int         gap_left = 0;
  int         sent_cnt = 0;
  bit         drain_hold = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // transaction pending, payload holds
    end else begin
      calm = text_q.size() < CALM_ITEMS;
      if (drain_hold && !in_valid && expected_q.size() == 0) drain_hold = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (drain_hold || text_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        nxt = text_q.pop_front();
        in_byte   <= nxt.data;
        input_end <= nxt.at_end;
        in_valid  <= 1'b1;
        sent_cnt++;
        if (sent_cnt == DRAIN_AT) drain_hold = 1'b1;
        // keep offering while the receiver is held off
        if (!calm && hold_left == 0 && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 11);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each input transaction, checks each output transaction,
  // and paces out_ready
  // ---------------------------------------------------------------------------

  unesc_result_t want;
  int            stall_left = 0;
  bit            held_once = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_unescape(in_byte, input_end);
        taken_cnt++;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result: byte %h kind %0d last %b", out_byte, kind, last);
        end else begin
          want = expected_q.pop_front();
          if (want.data !== out_byte || want.kind !== kind || want.last !== last) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: expected byte %h kind %0d last %b, got byte %h kind %0d last %b",
                       want.data, want.kind, want.last, out_byte, kind, last);
          end
        end
      end
      // one long hold so the internal queue fills and in_ready drops
      if (!held_once && taken_cnt >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run after a long stretch with no transaction
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("** json_string_unescape_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    // plain byte extremes, then the closing quote
    queue_byte(8'h20, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(CH_QUOTE, 1'b0);
    // raw control bytes
    queue_byte(8'h1F, 1'b0);
    queue_byte(8'h00, 1'b0);
    // every simple escape, then an unknown one
    queue_text("\\\"\\\\\\/\\b\\f\\n\\r\\t");
    queue_text("\\q");
    // one, two, three and four byte encodings, lone low surrogate
    queue_u_escape(16'h0000);
    queue_u_escape(16'h07FF);
    queue_u_escape(16'hFFFF);
    queue_u_escape(16'hDBFF);
    queue_u_escape(16'hDFFF);
    queue_u_escape(16'hDC00);
    queue_byte(CH_QUOTE, 1'b0);
    // high surrogate followed by a quote, then by a low half out of range
    queue_u_escape(16'hD800);
    queue_byte(CH_QUOTE, 1'b0);
    queue_u_escape(16'hD800);
    queue_u_escape(16'hE000);
    // bad hex digit
    queue_text("\\u00g");
    // end of text between strings
    queue_byte(8'hA5, 1'b1);

    // random part: mostly well-formed strings, some raw noise
    while (item_total < 430) begin
      if ($urandom_range(0, 99) < 85) begin
        queue_string();
      end else begin
        repeat ($urandom_range(1, 4))
          queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (taken_cnt < item_total) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) fail_cnt++;

    if (fail_cnt == 0) $display("** json_string_unescape_unit: PASSED **");
    else $display("** json_string_unescape_unit: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_unit.sv
tb/sv/tb.sv
